// ===== rtl/nrp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrp_pkg
// Shared types and constants for the nested region profiler.
// ----------------------------------------------------------------------------
package nrp_pkg;

    localparam int SLOTS = 16;
    localparam int SW = $clog2(SLOTS);
    localparam int PW = SW + 1;
    localparam logic [14:0] FULL_PCT = 15'd25600;

    typedef enum logic [2:0] {
        MODE_OPEN  = 3'd0,
        MODE_CLOSE = 3'd1,
        MODE_REPORT = 3'd2,
        MODE_RST1  = 3'd3,
        MODE_RSTALL = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_FULL     = 3'd2,
        ST_DISABLED = 3'd3,
        ST_NONE     = 3'd4,
        ST_NOKEY    = 3'd5,
        ST_EMPTY    = 3'd6
    } status_t;

    // Divider request and answer
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } div_rsp_t;

endpackage

// ===== rtl/nrp_if.sv =====
// ----------------------------------------------------------------------------
// nrp_if
// Valid/ready channels for the profiler: request, result and configuration.
// ----------------------------------------------------------------------------
interface nrp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] region_key;
    logic [31:0] timestamp;
    modport source (output valid, mode, region_key, timestamp, input ready);
    modport sink (input valid, mode, region_key, timestamp, output ready);
endinterface

interface nrp_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [15:0]        result_key;
    logic [14:0]        percent;
    logic signed [15:0] min_percent;
    logic [14:0]        avg_percent;
    logic signed [15:0] max_percent;
    logic [31:0]        self_time;
    logic [15:0]        call_count;
    logic [4:0]         depth;
    logic [31:0]        frame_time;
    logic               last;
    modport source (output valid, status, slot, result_key, percent, min_percent,
        avg_percent, max_percent, self_time, call_count, depth, frame_time, last,
        input ready);
    modport sink (input valid, status, slot, result_key, percent, min_percent,
        avg_percent, max_percent, self_time, call_count, depth, frame_time, last,
        output ready);
endinterface

interface nrp_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/nrp_div.sv =====
// ----------------------------------------------------------------------------
// nrp_div
// Restoring divider, one quotient bit per cycle, 48-bit by 33-bit.
// ----------------------------------------------------------------------------
module nrp_div
    import nrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;

    // One shift-subtract step per cycle; done holds until the next start
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = {rem_reg, quo_reg[47]} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[47]};
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== rtl/nested_region_profiler_unit.sv =====
// ----------------------------------------------------------------------------
// nested_region_profiler_unit
// Hierarchical frame profiler over a table of timed regions found by key.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per transfer (mode, region_key, timestamp).
//   rsp  : one or more results per known-mode request; last marks the end.
//   cfg  : one-bit enable; user writes only while the block is idle, unchecked.
// Flow:
//   Every request first passes the dispatch state, which waits for a free
//   output register. Open, reset-one and reset-all then scan the table one
//   slot per cycle and register their result in S_OPEN. Close registers its
//   result in S_CLOSE. Report skips empty slots; a valid slot runs the
//   shared 48-step serial divider for the share and again for the running
//   mean (the share division is skipped when the frame time is zero).
//   req.ready is high only while the sequencer is idle; one request is
//   worked on at a time.
// Reset:
//   Valid/open flags clear at once, min/max read -1 and average/count read 0;
//   the block is ready right after reset.
// Stall:
//   Each result waits in the output register until rsp.ready; the sequencer
//   holds meanwhile.
// ----------------------------------------------------------------------------
module nested_region_profiler_unit
    import nrp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    nrp_req_if.sink   req,
    nrp_rsp_if.source rsp,
    nrp_cfg_if.sink   cfg
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_OPEN  = 9'b000000100,
        S_CLOSE = 9'b000001000,
        S_RVIS  = 9'b000010000,
        S_RPCT  = 9'b000100000,
        S_RAVG  = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_WAIT  = 9'b100000000
    } state_t;

    state_t state_reg;

    // Table
    logic [SLOTS-1:0] valid_reg, open_reg;
    logic [15:0] key_mem [SLOTS];
    logic [PW-1:0] par_mem [SLOTS];
    logic [4:0]  dep_mem [SLOTS];
    logic [31:0] start_mem [SLOTS];
    logic [31:0] tot_mem [SLOTS];
    logic [31:0] chd_mem [SLOTS];
    logic [15:0] calls_mem [SLOTS];
    logic [15:0] avg_mem [SLOTS];
    logic [15:0] min_mem [SLOTS];
    logic [15:0] max_mem [SLOTS];
    logic [15:0] rep_mem [SLOTS];

    logic [PW-1:0] inner_reg;
    logic [4:0]    odep_reg;
    logic [31:0]   rbeg_reg, rend_reg;
    logic          en_reg;

    // Request latch and scan
    logic [2:0]    mode_reg;
    logic [15:0]   key_reg;
    logic [31:0]   ts_reg;
    logic [PW-1:0] idx_reg;
    logic [PW-1:0] hit_reg, free_reg;
    logic          any_reg;
    logic [14:0]   pct_reg;

    // Output register
    logic        ovalid_reg;
    logic [2:0]  ost_reg;
    logic [3:0]  oslot_reg;
    logic [15:0] okey_reg;
    logic [14:0] opct_reg, oavg_reg;
    logic [15:0] omin_reg, omax_reg, ocalls_reg;
    logic [31:0] oself_reg, oframe_reg;
    logic [4:0]  odepth_reg;
    logic        olast_reg;

    div_req_t dreq;
    div_req_t mreq;
    div_rsp_t drsp;

    nrp_div u_div (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(drsp));

    logic [SW-1:0] ix, hx, ipx;
    logic [31:0]   frame, self_t, taken;
    logic [15:0]   cnt;
    logic          out_free;
    logic          req_go;

    assign ix     = idx_reg[SW-1:0];
    assign hx     = hit_reg[SW-1:0];
    assign ipx    = inner_reg[SW-1:0];
    assign frame  = rend_reg - rbeg_reg;
    assign self_t = tot_mem[ix] - chd_mem[ix];
    assign taken  = ts_reg - start_mem[ipx];
    assign cnt    = rep_mem[ix];
    assign out_free = !ovalid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_go = req.valid && req.ready;

    function automatic logic [14:0] pct_sat(input logic [47:0] q);
        pct_sat = (q > 48'(FULL_PCT)) ? FULL_PCT : q[14:0];
    endfunction

    // Divider start for share and mean
    always_comb
    begin
        dreq = '0;
        if (state_reg == S_RVIS && idx_reg != PW'(SLOTS) && valid_reg[ix]
            && frame != 32'd0)
        begin
            dreq.start = 1'b1;
            dreq.num   = 48'(self_t) * 48'd25600;
            dreq.den   = {1'b0, frame};
        end
        else if (state_reg == S_RPCT && drsp.done)
        begin
            dreq.start = 1'b1;
            dreq.num   = 48'(32'(avg_mem[ix]) * 32'(cnt)) + 48'(pct_sat(drsp.quo));
            dreq.den   = 33'(cnt) + 33'd1;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            open_reg   <= '0;
            inner_reg  <= PW'(SLOTS);
            odep_reg   <= '0;
            rbeg_reg   <= '0;
            rend_reg   <= '0;
            en_reg     <= 1'b1;
            ovalid_reg <= 1'b0;
            rep_mem    <= '{default: 16'd0};
            avg_mem    <= '{default: 16'd0};
            min_mem    <= '{default: 16'hFFFF};
            max_mem    <= '{default: 16'hFFFF};
        end
        else
        begin
            if (cfg.valid) en_reg <= cfg.data;
            if (ovalid_reg && rsp.ready) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_go)
                    begin
                        mode_reg <= req.mode;
                        key_reg  <= req.region_key;
                        ts_reg   <= req.timestamp;
                        idx_reg  <= '0;
                        hit_reg  <= PW'(SLOTS);
                        free_reg <= PW'(SLOTS);
                        any_reg  <= 1'b0;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    // Dispatch
                    if (out_free)
                    begin
                        if (mode_reg > MODE_RSTALL)
                            state_reg <= S_IDLE;
                        else if (!en_reg)
                        begin
                            ovalid_reg <= 1'b1; ost_reg <= ST_DISABLED;
                            oslot_reg <= '0; okey_reg <= '0; odepth_reg <= '0;
                            ocalls_reg <= '0; {opct_reg, oavg_reg, omin_reg, omax_reg} <= '0;
                            oself_reg <= '0; oframe_reg <= '0; olast_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (mode_reg == MODE_CLOSE)
                            state_reg <= S_CLOSE;
                        else if (mode_reg == MODE_REPORT)
                            state_reg <= S_RVIS;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // One slot per cycle for open, reset one and reset all
                    if (idx_reg == PW'(SLOTS))
                        state_reg <= S_OPEN;
                    else
                    begin
                        if (mode_reg == MODE_RSTALL)
                        begin
                            if (valid_reg[ix])
                            begin
                                min_mem[ix] <= 16'hFFFF; max_mem[ix] <= 16'hFFFF;
                                rep_mem[ix] <= '0; avg_mem[ix] <= '0;
                                if (!open_reg[ix]) valid_reg[ix] <= 1'b0;
                            end
                        end
                        else if (!valid_reg[ix])
                        begin
                            if (free_reg == PW'(SLOTS)) free_reg <= idx_reg;
                        end
                        else if (key_mem[ix] == key_reg && hit_reg == PW'(SLOTS))
                            hit_reg <= idx_reg;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OPEN:
                begin
                    ovalid_reg <= 1'b1; olast_reg <= 1'b1;
                    {opct_reg, oavg_reg, omin_reg, omax_reg} <= '0;
                    oself_reg <= '0; oframe_reg <= '0; ocalls_reg <= '0;
                    oslot_reg <= '0; okey_reg <= '0; odepth_reg <= '0;
                    state_reg <= S_IDLE;
                    if (mode_reg == MODE_RSTALL)
                        ost_reg <= ST_OK;
                    else if (mode_reg == MODE_RST1)
                    begin
                        if (hit_reg == PW'(SLOTS))
                            ost_reg <= ST_NOKEY;
                        else
                        begin
                            ost_reg <= ST_OK;
                            oslot_reg <= 4'(hit_reg); okey_reg <= key_mem[hx];
                            odepth_reg <= dep_mem[hx];
                            min_mem[hx] <= 16'hFFFF; max_mem[hx] <= 16'hFFFF;
                            rep_mem[hx] <= '0; avg_mem[hx] <= '0;
                        end
                    end
                    else if (hit_reg != PW'(SLOTS) && open_reg[hx])
                    begin
                        ost_reg <= ST_ALREADY;
                        oslot_reg <= 4'(hit_reg); okey_reg <= key_mem[hx];
                        odepth_reg <= dep_mem[hx];
                    end
                    else if (hit_reg == PW'(SLOTS) && free_reg == PW'(SLOTS))
                        ost_reg <= ST_FULL;
                    else
                    begin
                        // Claim the found or free slot and push it
                        logic [SW-1:0] t;
                        logic [15:0] nc;
                        t = (hit_reg != PW'(SLOTS)) ? hx : free_reg[SW-1:0];
                        nc = (hit_reg != PW'(SLOTS))
                            ? ((calls_mem[t] == 16'hFFFF) ? 16'hFFFF : calls_mem[t] + 16'd1)
                            : 16'd1;
                        if (hit_reg == PW'(SLOTS))
                        begin
                            valid_reg[t] <= 1'b1; key_mem[t] <= key_reg;
                            tot_mem[t] <= '0; chd_mem[t] <= '0;
                        end
                        calls_mem[t] <= nc;
                        par_mem[t] <= inner_reg;
                        inner_reg <= PW'(t);
                        dep_mem[t] <= odep_reg;
                        if (odep_reg < 5'(SLOTS)) odep_reg <= odep_reg + 5'd1;
                        open_reg[t] <= 1'b1;
                        start_mem[t] <= ts_reg;
                        if (inner_reg >= PW'(SLOTS)) rbeg_reg <= ts_reg;
                        ost_reg <= ST_OK; oslot_reg <= 4'(t); okey_reg <= key_reg;
                        odepth_reg <= odep_reg; ocalls_reg <= nc;
                    end
                end
                S_CLOSE:
                begin
                    ovalid_reg <= 1'b1; olast_reg <= 1'b1;
                    {opct_reg, oavg_reg, omin_reg, omax_reg} <= '0;
                    oself_reg <= '0; oframe_reg <= '0; ocalls_reg <= '0;
                    oslot_reg <= '0; okey_reg <= '0; odepth_reg <= '0;
                    state_reg <= S_IDLE;
                    if (inner_reg >= PW'(SLOTS))
                        ost_reg <= ST_NONE;
                    else
                    begin
                        open_reg[ipx] <= 1'b0;
                        if (par_mem[ipx] < PW'(SLOTS))
                            chd_mem[par_mem[ipx][SW-1:0]] <= chd_mem[par_mem[ipx][SW-1:0]] + taken;
                        else
                            rend_reg <= ts_reg;
                        tot_mem[ipx] <= tot_mem[ipx] + taken;
                        inner_reg <= par_mem[ipx];
                        if (odep_reg > 5'd0) odep_reg <= odep_reg - 5'd1;
                        ost_reg <= ST_OK; oslot_reg <= 4'(inner_reg);
                        okey_reg <= key_mem[ipx]; odepth_reg <= dep_mem[ipx];
                    end
                end
                S_RVIS:
                begin
                    // Walk slots; start share division on a valid one with a nonzero frame
                    if (idx_reg == PW'(SLOTS))
                    begin
                        state_reg <= S_IDLE;
                        if (!any_reg)
                        begin
                            ovalid_reg <= 1'b1; olast_reg <= 1'b1; ost_reg <= ST_EMPTY;
                            {opct_reg, oavg_reg, omin_reg, omax_reg} <= '0;
                            oself_reg <= '0; oframe_reg <= '0; ocalls_reg <= '0;
                            oslot_reg <= '0; okey_reg <= '0; odepth_reg <= '0;
                        end
                    end
                    else if (!valid_reg[ix])
                        idx_reg <= idx_reg + 1'b1;
                    else if (frame == 32'd0)
                    begin
                        pct_reg <= (self_t == 32'd0) ? 15'd0 : FULL_PCT;
                        state_reg <= S_RAVG;
                        any_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_RPCT;
                        any_reg <= 1'b1;
                    end
                end
                S_RPCT:
                begin
                    if (drsp.done)
                    begin
                        pct_reg <= pct_sat(drsp.quo);
                        hit_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_RAVG:
                begin
                    // Zero frame: start mean division with a fixed share
                    state_reg <= S_EMIT;
                    hit_reg <= '0;
                end
                S_EMIT:
                begin
                    if (drsp.done && out_free)
                    begin
                        logic [15:0] nmin, nmax, p16;
                        logic [PW-1:0] nx;
                        logic more;
                        p16 = {1'b0, pct_reg};
                        nmin = (min_mem[ix] == 16'hFFFF || $signed(p16) < $signed(min_mem[ix]))
                            ? p16 : min_mem[ix];
                        nmax = (max_mem[ix] == 16'hFFFF || $signed(p16) > $signed(max_mem[ix]))
                            ? p16 : max_mem[ix];
                        more = 1'b0;
                        for (int k = 0; k < SLOTS; k++)
                            if (PW'(k) > idx_reg && valid_reg[k]) more = 1'b1;
                        nx = idx_reg + 1'b1;
                        avg_mem[ix] <= drsp.quo[15:0];
                        if (cnt != 16'hFFFF) rep_mem[ix] <= cnt + 16'd1;
                        min_mem[ix] <= nmin; max_mem[ix] <= nmax;
                        ovalid_reg <= 1'b1; ost_reg <= ST_OK;
                        oslot_reg <= 4'(idx_reg); okey_reg <= key_mem[ix];
                        opct_reg <= pct_reg; omin_reg <= nmin;
                        oavg_reg <= drsp.quo[14:0]; omax_reg <= nmax;
                        oself_reg <= self_t; ocalls_reg <= calls_mem[ix];
                        odepth_reg <= dep_mem[ix]; oframe_reg <= frame;
                        olast_reg <= !more;
                        calls_mem[ix] <= '0; tot_mem[ix] <= '0; chd_mem[ix] <= '0;
                        idx_reg <= nx;
                        state_reg <= more ? S_RVIS : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Mean division launch, aligned for both share paths
    always_comb
    begin
        mreq = dreq;
        if (state_reg == S_RAVG)
        begin
            mreq.start = 1'b1;
            mreq.num = 48'(32'(avg_mem[ix]) * 32'(cnt)) + 48'(pct_reg);
            mreq.den = 33'(cnt) + 33'd1;
        end
    end

    // Output mapping
    assign rsp.valid       = ovalid_reg;
    assign rsp.status      = ost_reg;
    assign rsp.slot        = oslot_reg;
    assign rsp.result_key  = okey_reg;
    assign rsp.percent     = opct_reg;
    assign rsp.min_percent = omin_reg;
    assign rsp.avg_percent = oavg_reg;
    assign rsp.max_percent = omax_reg;
    assign rsp.self_time   = oself_reg;
    assign rsp.call_count  = ocalls_reg;
    assign rsp.depth       = odepth_reg;
    assign rsp.frame_time  = oframe_reg;
    assign rsp.last        = olast_reg;

endmodule
